@@ rtl/core/spif_pkg.sv @@
// spif_pkg: shared types, codes and the crc-8 step of the spi framer
// no dependencies; imported by every module of the framer but spif_checker
package spif_pkg;

    localparam int unsigned CRC_POLY = 8'h07;
    localparam int unsigned QDEPTH   = 2;
    localparam int unsigned QAW      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam int unsigned IN_TDATA_W  = 88;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic [1:0] CFG_CRC_EN   = 2'd0;
    localparam logic [1:0] CFG_CTRL_FLG = 2'd1;
    localparam logic [1:0] CFG_WR_FLG   = 2'd2;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_RESP  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef struct packed {
        t_req        kind;
        logic [7:0]  hdr0;
        logic [7:0]  hdr1;
        logic [31:0] word;
        logic [7:0]  rcrc;
    } t_desc;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY[7:0]) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = w[31:24];
            2'd1: b = w[23:16];
            2'd2: b = w[15:8];
            2'd3: b = w[7:0];
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/spif_front.sv @@
// spif_front: accepts request beats, classifies them and builds the header bytes
// depends on spif_pkg
module spif_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  spif_pkg::t_req         i_req,
    input  logic [12:0]            i_reg_address,
    input  logic [31:0]            i_write_value,
    input  logic [31:0]            i_received_word,
    input  logic [7:0]             i_received_crc,
    input  logic [7:0]             i_ctrl_flags,
    input  logic [7:0]             i_wr_flags,
    output logic                   o_valid,
    output spif_pkg::t_desc        o_desc,
    input  logic                   i_q_ready
);
    import spif_pkg::*;

    logic  r_valid, n_valid;
    t_desc r_desc, n_desc;
    logic  accept;

    assign o_s_tready = !r_valid || i_q_ready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_valid    = r_valid;
    assign o_desc     = r_desc;

    always_comb begin
        n_valid = r_valid && !i_q_ready;
        n_desc  = r_desc;
        if (accept && i_req != REQ_NONE) begin
            n_valid     = 1'b1;
            n_desc.kind = i_req;
            n_desc.hdr0 = i_ctrl_flags | ((i_req == REQ_WRITE) ? i_wr_flags : 8'h00)
                        | {3'b000, i_reg_address[12:8]};
            n_desc.hdr1 = i_reg_address[7:0];
            n_desc.word = (i_req == REQ_WRITE) ? i_write_value : i_received_word;
            n_desc.rcrc = i_received_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_desc <= n_desc;
    end

endmodule

@@ rtl/core/spif_queue.sv @@
// spif_queue: short descriptor queue between the front and the byte engine
// depends on spif_pkg
module spif_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  spif_pkg::t_desc i_desc,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output spif_pkg::t_desc o_desc
);
    import spif_pkg::*;

    t_desc            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    logic             push, pop;

    assign o_ready = r_cnt != (QAW+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_desc  = r_mem[r_rp];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QAW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(pop);
        end
        if (push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

endmodule

@@ rtl/core/spif_back.sv @@
// spif_back: byte engine with running crc-8 and output register, one beat per cycle
// while the output is not stalled and no response check runs; depends on spif_pkg
module spif_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_crc_en,
    input  logic            i_valid,
    input  spif_pkg::t_desc i_desc,
    output logic            o_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_byte,
    output logic [31:0]     o_read_value,
    output logic            o_crc_error
);
    import spif_pkg::*;

    typedef enum logic [5:0] {
        S_START = 6'b000001,
        S_HDR1  = 6'b000010,
        S_HCRC  = 6'b000100,
        S_BODY  = 6'b001000,
        S_DCRC  = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_cnt, n_cnt;
    logic [7:0]  r_crc, n_crc;
    logic        r_m_valid;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [31:0] r_val;
    logic        r_err;

    logic        slot_free, emit, e_last, e_err;
    logic [7:0]  e_byte, w_byte;
    logic [31:0] e_val;

    assign slot_free = !r_m_valid || i_m_tready;
    assign w_byte    = word_byte(i_desc.word, r_cnt[1:0]);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        emit    = 1'b0;
        e_byte  = 8'h00;
        e_last  = 1'b0;
        e_val   = 32'h0;
        e_err   = 1'b0;
        o_pop   = 1'b0;
        unique case (r_state)
            S_START: begin
                if (i_valid) begin
                    if (i_desc.kind == REQ_RESP) begin
                        n_crc   = crc8_byte(8'h00, i_desc.word[31:24]);
                        n_cnt   = 3'd1;
                        n_state = S_RESP;
                    end else if (slot_free) begin
                        emit    = 1'b1;
                        e_byte  = i_desc.hdr0;
                        n_crc   = crc8_byte(8'h00, i_desc.hdr0);
                        n_state = S_HDR1;
                    end
                end
            end
            S_HDR1: begin
                if (slot_free) begin
                    emit   = 1'b1;
                    e_byte = i_desc.hdr1;
                    n_cnt  = 3'd0;
                    if (i_crc_en) begin
                        n_crc   = crc8_byte(r_crc, i_desc.hdr1);
                        n_state = S_HCRC;
                    end else begin
                        n_crc   = 8'h00;
                        n_state = S_BODY;
                    end
                end
            end
            S_HCRC: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_byte  = r_crc;
                    n_crc   = 8'h00;
                    n_cnt   = 3'd0;
                    n_state = S_BODY;
                end
            end
            S_BODY: begin
                if (slot_free) begin
                    emit  = 1'b1;
                    n_cnt = r_cnt + 3'd1;
                    if (i_desc.kind == REQ_WRITE) begin
                        e_byte = w_byte;
                        n_crc  = crc8_byte(r_crc, w_byte);
                        if (r_cnt == 3'd3) begin
                            if (i_crc_en) begin
                                n_state = S_DCRC;
                            end else begin
                                e_last  = 1'b1;
                                o_pop   = 1'b1;
                                n_state = S_START;
                            end
                        end
                    end else if (r_cnt == (i_crc_en ? 3'd5 : 3'd4)) begin
                        e_last  = 1'b1;
                        o_pop   = 1'b1;
                        n_state = S_START;
                    end
                end
            end
            S_DCRC: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_byte  = r_crc;
                    e_last  = 1'b1;
                    o_pop   = 1'b1;
                    n_state = S_START;
                end
            end
            S_RESP: begin
                if (r_cnt != 3'd4) begin
                    n_crc = crc8_byte(r_crc, w_byte);
                    n_cnt = r_cnt + 3'd1;
                end else if (slot_free) begin
                    emit    = 1'b1;
                    e_last  = 1'b1;
                    e_val   = i_desc.word;
                    e_err   = i_crc_en && (r_crc != i_desc.rcrc);
                    o_pop   = 1'b1;
                    n_state = S_START;
                end
            end
            default: begin
                n_state = S_START;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_START;
            r_cnt     <= 3'd0;
            r_crc     <= 8'h00;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (emit) begin
            r_byte <= e_byte;
            r_last <= e_last;
            r_val  <= e_val;
            r_err  <= e_err;
        end
    end

    assign o_m_tvalid   = r_m_valid;
    assign o_out_byte   = r_byte;
    assign o_last_byte  = r_last;
    assign o_read_value = r_val;
    assign o_crc_error  = r_err;

endmodule

@@ rtl/core/spi_register_access_framer_crc8.sv @@
// spi_register_access_framer_crc8: top level of the register-access spi framer
// depends on spif_pkg, spif_front, spif_queue, spif_back
//
// Each request beat turns into the byte beats of one spi register transaction, one beat
// per cycle from the byte engine while the output is not stalled: a write is 6 beats
// (8 with crc on), a read 7 (9 with crc on), and a response check runs four crc-8 byte
// steps, then its single beat. The front stage and a two-entry queue take new requests
// while the engine is busy, so back-to-back requests run at the engine's byte rate; output
// stalls hold the engine, and the input only once the queue and the front stage are full.
// Crc is crc-8, polynomial 0x07, msb first, initial value 0. Registers: 0 crc enable,
// 1 control flag bits, 2 write flag bits; write them only while the framer is idle.
module spi_register_access_framer_crc8 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // reg_address, write_value, received_word, received_crc
    input  logic [spif_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic [1:0]                      s_axis_tuser,  // req_type
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_byte, read_value
    output logic [spif_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    output logic [0:0]                      m_axis_tuser,  // crc_error
    input  logic                            i_cfg_wr_en,
    input  logic [1:0]                      i_cfg_index,
    input  logic [7:0]                      i_cfg_wdata
);
    import spif_pkg::*;

    logic        r_crc_en;
    logic [7:0]  r_ctrl_flags;
    logic [7:0]  r_wr_flags;

    logic        f_valid, q_ready, q_valid, q_pop;
    t_desc       f_desc, q_desc;
    logic [7:0]  out_byte;
    logic [31:0] read_value;
    logic        crc_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_en     <= 1'b0;
            r_ctrl_flags <= 8'h80;
            r_wr_flags   <= 8'h20;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CRC_EN:   r_crc_en     <= i_cfg_wdata[0];
                CFG_CTRL_FLG: r_ctrl_flags <= i_cfg_wdata;
                CFG_WR_FLG:   r_wr_flags   <= i_cfg_wdata;
                default:      ;
            endcase
        end
    end

    spif_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .o_s_tready      (s_axis_tready),
        .i_req           (t_req'(s_axis_tuser)),
        .i_reg_address   (s_axis_tdata[12:0]),
        .i_write_value   (s_axis_tdata[44:13]),
        .i_received_word (s_axis_tdata[76:45]),
        .i_received_crc  (s_axis_tdata[84:77]),
        .i_ctrl_flags    (r_ctrl_flags),
        .i_wr_flags      (r_wr_flags),
        .o_valid         (f_valid),
        .o_desc          (f_desc),
        .i_q_ready       (q_ready)
    );

    spif_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_desc  (f_desc),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    spif_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_crc_en     (r_crc_en),
        .i_valid      (q_valid),
        .i_desc       (q_desc),
        .o_pop        (q_pop),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_out_byte   (out_byte),
        .o_last_byte  (m_axis_tlast),
        .o_read_value (read_value),
        .o_crc_error  (crc_error)
    );

    assign m_axis_tdata = {read_value, out_byte};
    assign m_axis_tuser = crc_error;

endmodule

@@ rtl/core/spif_checker.sv @@
// spif_checker: port-level assertions for the spi framer, bound to the top level
// depends on spi_register_access_framer_crc8 port names
module spif_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [39:0]  m_axis_tdata,
    input logic         m_axis_tlast,
    input logic [0:0]   m_axis_tuser
);

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata[7:0] == 8'h00)
        else $error("crc error flag on a byte beat");

    a_val_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[39:8] != 32'h0 |-> m_axis_tlast
            && m_axis_tdata[7:0] == 8'h00)
        else $error("read value on a byte beat");

endmodule

bind spi_register_access_framer_crc8 spif_checker u_spif_checker (.*);
